@@ design/hvn_pkg.sv @@
// Shared widths, state encoding and lane helpers for the hash vector normalizer.
package hvn_pkg;

  localparam int LaneW    = 32;   // one digest lane
  localparam int SqW      = 64;   // square of a centered lane magnitude
  localparam int SumW     = 70;   // sum of up to 64 squares
  localparam int RootW    = 36;   // floor root of a SumW value
  localparam int QuoW     = 31;   // rounded quotient, at most 2^30
  localparam int LenW     = 7;    // vector_length register
  localparam int IdxW     = 6;    // element index
  localparam int NumLanes = 6;
  localparam int SelW     = 3;    // lane select

  localparam logic [LenW-1:0] MaxLength = 7'd64;
  localparam logic [SelW-1:0] LastLane  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIVIDE,
    ST_EMIT
  } hvn_state_e;

  // Magnitude of 2u - (2^32-1): always odd, low half mirrored below the midpoint
  function automatic logic [LaneW-1:0] lane_mag(input logic [LaneW-1:0] u);
    lane_mag = u[LaneW-1] ? {u[LaneW-2:0], 1'b1} : {~u[LaneW-2:0], 1'b1};
  endfunction

  // Centered lane is negative when the lane sits below the midpoint
  function automatic logic lane_neg(input logic [LaneW-1:0] u);
    lane_neg = ~u[LaneW-1];
  endfunction

endpackage

@@ design/hash_vector_normalizer_core.sv @@
// Top level of the hash vector normalizer: sequencer, lane stores and result port.
//
// Usage: pulse start with the three digest words while busy is low; the request
// is taken at that edge and busy rises on the next cycle (it stays low when the
// clamped length is zero). cfg_we_i/cfg_wdata_i set the vector length L (values
// above 64 act as 64, zero emits nothing). The user must write them only while
// busy is low; the block does not enforce this. Results leave one per cycle on
// element_index_o/element_value_o/last_element_o, each valid for the single
// cycle result_strobe_o is high; the receiver cannot stall the block, so there
// is no back-pressure. Requests are served one at a time. A request runs through
// the bit-serial units in order: six lane squarings, a sum walk over the L
// elements, a square root, six divisions (one per distinct lane), then an emit
// walk over the L elements, with a launch and handoff step around each unit run.
// The last result is on the port in the first cycle with busy low again.
// Reset: the length register returns to 64, the sequencer to idle and the
// result strobe low.
module hash_vector_normalizer_core
  import hvn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        digest_word_a_i,
  input  logic [63:0]        digest_word_b_i,
  input  logic [63:0]        digest_word_c_i,
  input  logic               cfg_we_i,
  input  logic [LenW-1:0]    cfg_wdata_i,
  output logic               result_strobe_o,
  output logic [IdxW-1:0]    element_index_o,
  output logic signed [31:0] element_value_o,
  output logic               last_element_o
);

  hvn_state_e state_q, state_d;

  logic [LenW-1:0]  vector_length_q;
  logic [LenW-1:0]  len_clamped;
  logic [LenW-1:0]  len_q;
  logic [LaneW-1:0] lane_q [NumLanes];
  logic [SqW-1:0]   sq_q [NumLanes];
  logic [31:0]      val_q [NumLanes];
  logic [SumW-1:0]  sum_q;
  logic [RootW-1:0] root_q;
  logic [SelW-1:0]  sel_q;
  logic [IdxW-1:0]  idx_q;
  logic [1:0]       word_q;
  logic             kick_q;

  logic             strobe_q;
  logic [IdxW-1:0]  index_q;
  logic [31:0]      value_q;
  logic             last_q;

  logic             accept;
  logic             walk_last;
  logic [SelW-1:0]  walk_sel;
  logic             sq_start, root_start, div_start;
  logic             sq_done, root_done, div_done;
  logic [SqW-1:0]   sq_res;
  logic [RootW-1:0] root_res;
  logic [QuoW-1:0]  quo_res;
  logic [31:0]      quo_mag;
  logic [31:0]      signed_val;

  assign accept      = start && !busy;
  assign len_clamped = (vector_length_q > MaxLength) ? MaxLength : vector_length_q;
  assign walk_last   = ({1'b0, idx_q} == (len_q - 7'd1));

  // Element k reads word (k/2 mod 3), low lane on even k
  assign walk_sel = {word_q, idx_q[0]};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept && (len_clamped != '0)) state_d = ST_SQUARE;
      ST_SQUARE: if (sq_done && (sel_q == LastLane)) state_d = ST_SUM;
      ST_SUM:    if (walk_last) state_d = ST_ROOT;
      ST_ROOT:   if (root_done) state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_done && (sel_q == LastLane)) state_d = ST_EMIT;
      ST_EMIT:   if (walk_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Unit launches
  always_comb begin
    sq_start   = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_SQUARE: sq_start   = kick_q;
      ST_ROOT:   root_start = kick_q;
      ST_DIVIDE: div_start  = kick_q;
      default: begin
        sq_start   = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  hvn_square u_square (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (lane_mag(lane_q[sel_q])),
    .done_o    (sq_done),
    .square_o  (sq_res)
  );

  hvn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_q),
    .done_o     (root_done),
    .root_o     (root_res)
  );

  hvn_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .mag_i      (lane_mag(lane_q[sel_q])),
    .root_i     (root_q),
    .done_o     (div_done),
    .quotient_o (quo_res)
  );

  // Apply the lane sign; a zero root forces a zero element
  assign quo_mag    = (root_q == '0) ? '0 : {1'b0, quo_res};
  assign signed_val = lane_neg(lane_q[sel_q]) ? (~quo_mag + 32'd1) : quo_mag;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      vector_length_q <= MaxLength;
      len_q           <= '0;
      sel_q           <= '0;
      idx_q           <= '0;
      word_q          <= '0;
      kick_q          <= 1'b0;
      strobe_q        <= 1'b0;
      last_q          <= 1'b0;
    end else begin
      state_q  <= state_d;
      kick_q   <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      if (cfg_we_i) begin
        vector_length_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            len_q  <= len_clamped;
            sel_q  <= '0;
            kick_q <= (len_clamped != '0);
          end
        end
        ST_SQUARE: begin
          if (sq_done) begin
            if (sel_q != LastLane) begin
              sel_q  <= sel_q + 3'd1;
              kick_q <= 1'b1;
            end else begin
              idx_q  <= '0;
              word_q <= '0;
            end
          end
        end
        ST_SUM, ST_EMIT: begin
          // Advance the element walk
          idx_q <= idx_q + 6'd1;
          if (idx_q[0]) begin
            word_q <= (word_q == 2'd2) ? 2'd0 : word_q + 2'd1;
          end
          if (state_q == ST_SUM) begin
            kick_q <= walk_last;
          end else begin
            strobe_q <= 1'b1;
            last_q   <= walk_last;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            sel_q  <= '0;
            kick_q <= 1'b1;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            if (sel_q != LastLane) begin
              sel_q  <= sel_q + 3'd1;
              kick_q <= 1'b1;
            end else begin
              idx_q  <= '0;
              word_q <= '0;
            end
          end
        end
        default: kick_q <= 1'b0;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lane_q[0] <= digest_word_a_i[31:0];
      lane_q[1] <= digest_word_a_i[63:32];
      lane_q[2] <= digest_word_b_i[31:0];
      lane_q[3] <= digest_word_b_i[63:32];
      lane_q[4] <= digest_word_c_i[31:0];
      lane_q[5] <= digest_word_c_i[63:32];
      sum_q     <= '0;
    end
    if ((state_q == ST_SQUARE) && sq_done) begin
      sq_q[sel_q] <= sq_res;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_q + {{(SumW-SqW){1'b0}}, sq_q[walk_sel]};
    end
    if ((state_q == ST_ROOT) && root_done) begin
      root_q <= root_res;
    end
    if ((state_q == ST_DIVIDE) && div_done) begin
      val_q[sel_q] <= signed_val;
    end
    if (state_q == ST_EMIT) begin
      index_q <= idx_q;
      value_q <= val_q[walk_sel];
    end
  end

  assign result_strobe_o = strobe_q;
  assign element_index_o = index_q;
  assign element_value_o = value_q;
  assign last_element_o  = last_q;

`ifndef ASSERT_OFF
  // Results only come out of the emit walk
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe outside emit walk");

  // The last flag marks a delivered result
  a_last_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> result_strobe_o)
    else $error("last flag without result strobe");

  // Results of one vector come back to back with rising index
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_element_o) |=>
      (result_strobe_o && (element_index_o == ($past(element_index_o) + 6'd1))))
    else $error("element sequence broken");

  // The sum walk never starts on an empty vector
  a_sum_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> ((len_q != '0) && (len_q <= MaxLength)))
    else $error("sum walk with bad length");
`endif

endmodule

@@ design/hvn_square.sv @@
// Bit-serial shift-add squarer for one 32-bit lane magnitude.
module hvn_square
  import hvn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LaneW-1:0] operand_i,
  output logic             done_o,
  output logic [SqW-1:0]   square_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [LaneW-1:0] mcand_q, mcand_d;
  logic [LaneW-1:0] acc_hi_q, acc_hi_d;
  logic [LaneW-1:0] acc_lo_q, acc_lo_d;
  logic [LaneW:0]   step_sum;

  // Add the multiplicand when the outgoing multiplier bit is set
  assign step_sum = {1'b0, acc_hi_q} + (acc_lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_hi_d = acc_hi_q;
    acc_lo_d = acc_lo_q;
    if (busy_q) begin
      // Shift the partial product right one bit per cycle
      acc_hi_d = step_sum[LaneW:1];
      acc_lo_d = {step_sum[0], acc_lo_q[LaneW-1:1]};
      cnt_d    = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = operand_i;
      acc_hi_d = '0;
      acc_lo_d = operand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    acc_hi_q <= acc_hi_d;
    acc_lo_q <= acc_lo_d;
  end

  assign done_o   = done_q;
  assign square_o = {acc_hi_q, acc_lo_q};

endmodule

@@ design/hvn_sqrt.sv @@
// Digit-by-digit floor square root, two radicand bits per cycle.
module hvn_sqrt
  import hvn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             fits;

  // Bring down the next digit pair and try the next root bit
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (busy_q) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      rem_d  = fits ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_d = {root_q[RootW-2:0], fits};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = {{(RadW-SumW){1'b0}}, radicand_i};
      rem_d  = '0;
      root_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ design/hvn_divider.sv @@
// Bit-serial restoring divider giving round(mag * 2^30 / root), half up.
module hvn_divider
  import hvn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LaneW-1:0] mag_i,
  input  logic [RootW-1:0] root_i,
  output logic             done_o,
  output logic [QuoW-1:0]  quotient_o
);

  localparam int NumW = LaneW + QuoW + 1;
  localparam int DivW = RootW + 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [DivW-1:0]  divisor_q, divisor_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  nq_q, nq_d;
  logic [NumW-1:0]  numer;
  logic [DivW:0]    rem_sh;
  logic             fits;

  // Numerator is 2*mag*2^30 + root, divisor 2*root; quotient stays below 2^31
  assign numer  = {1'b0, mag_i, {QuoW{1'b0}}} + {{(NumW-RootW){1'b0}}, root_i};
  assign rem_sh = {rem_q, nq_q[QuoW-1]};
  assign fits   = (rem_sh >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    divisor_d = divisor_q;
    rem_d     = rem_q;
    nq_d      = nq_q;
    if (busy_q) begin
      // Shift numerator bits out and quotient bits in through one register
      rem_d = fits ? DivW'(rem_sh - {1'b0, divisor_q}) : DivW'(rem_sh);
      nq_d  = {nq_q[QuoW-2:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      divisor_d = {root_i, 1'b0};
      rem_d     = {{(DivW-(NumW-QuoW)){1'b0}}, numer[NumW-1:QuoW]};
      nq_d      = numer[QuoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    nq_q      <= nq_d;
  end

  assign done_o     = done_q;
  assign quotient_o = nq_q;

endmodule
